[hw/rtl/upd_pkg.sv]
package upd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int RES_MAX   = 4;   // results one word can cause
    localparam int CAND_MAX  = 3;   // data results one word can cause
    localparam int RES_CNT_W = 3;   // holds 0..RES_MAX
    localparam int RES_IDX_W = 2;
    localparam int CAND_IDX_W = 2;

    // escape phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEST_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_ZERO  = 8'd1;

    localparam logic [CNT_W-1:0] CAP_RESET = 16'd256;

    localparam logic [BYTE_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] HEX_ALPHA  = 8'd10;

    typedef struct packed {
        logic [1:0]        phase;
        logic [BYTE_W-1:0] held;
        logic [CNT_W-1:0]  written;
        logic              ovf;
        logic              skip;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              term;
        logic              trunc;
    } t_res;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UF)
            || (c >= CHAR_LA && c <= CHAR_LF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - CHAR_0;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v = c - CHAR_UA + HEX_ALPHA;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            v = c - CHAR_LA + HEX_ALPHA;
        end
        return v[3:0];
    endfunction

endpackage

[hw/rtl/upd_ifs.sv]
interface upd_in_if import upd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_string;
    modport source(output valid, output in_byte, output end_of_string, input ready);
    modport sink(input valid, input in_byte, input end_of_string, output ready);
endinterface

interface upd_out_if import upd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_terminator;
    logic              truncated;
    modport source(output valid, output out_byte, output is_terminator, output truncated,
                   input ready);
    modport sink(input valid, input out_byte, input is_terminator, input truncated,
                 output ready);
endinterface

interface upd_cfg_if import upd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

[hw/rtl/upd_step.sv]
module upd_step import upd_pkg::*; (
    input  t_state                    i_state,
    input  logic [BYTE_W-1:0]         i_byte,
    input  logic                      i_eos,
    input  logic [CNT_W-1:0]          i_cap,
    input  logic                      i_stop_at_zero,
    output t_state                    o_state,
    output t_res [RES_MAX-1:0]        o_res,
    output logic [RES_CNT_W-1:0]      o_count
);

    logic [BYTE_W-1:0]     cand [CAND_MAX];
    logic [CAND_IDX_W-1:0] ncand;
    logic                  consumed;
    logic                  zero_end;
    logic                  term;
    logic [CNT_W-1:0]      limit;
    t_state                s;
    t_res [RES_MAX-1:0]    res;
    logic [RES_CNT_W-1:0]  cnt;

    assign limit    = (i_cap == '0) ? '0 : i_cap - 1'b1;
    assign zero_end = i_stop_at_zero && (i_byte == CHAR_NUL);

    always_comb begin
        s        = i_state;
        ncand    = '0;
        consumed = 1'b0;
        term     = 1'b0;
        cnt      = '0;
        res      = '0;
        for (int k = 0; k < CAND_MAX; k++) begin
            cand[k] = '0;
        end

        if (i_state.skip) begin
            if (i_eos) begin
                s.skip = 1'b0;
            end
        end else begin
            // resolve a pending escape against this word
            case (i_state.phase)
                PH_PCT: begin
                    if (is_hex(i_byte)) begin
                        s.held   = i_byte;
                        s.phase  = PH_DIGIT;
                        consumed = 1'b1;
                    end else begin
                        cand[ncand] = CHAR_PCT;
                        ncand       = ncand + 1'b1;
                        s.phase     = PH_IDLE;
                        s.held      = '0;
                    end
                end
                PH_DIGIT: begin
                    if (is_hex(i_byte)) begin
                        cand[ncand] = {hex_val(i_state.held), hex_val(i_byte)};
                        ncand       = ncand + 1'b1;
                        consumed    = 1'b1;
                    end else begin
                        cand[ncand] = CHAR_PCT;
                        ncand       = ncand + 1'b1;
                        cand[ncand] = i_state.held;
                        ncand       = ncand + 1'b1;
                    end
                    s.phase = PH_IDLE;
                    s.held  = '0;
                end
                default: ;
            endcase

            if (!consumed && zero_end) begin
                // zero ends the string; skip to the end flag unless it is here
                term = 1'b1;
                if (!i_eos) begin
                    s.skip = 1'b1;
                end
            end else begin
                if (!consumed) begin
                    if (i_byte == CHAR_PCT) begin
                        s.phase = PH_PCT;
                    end else begin
                        cand[ncand] = i_byte;
                        ncand       = ncand + 1'b1;
                    end
                end
                if (i_eos) begin
                    term = 1'b1;
                    if (s.phase != PH_IDLE) begin
                        cand[ncand] = CHAR_PCT;
                        ncand       = ncand + 1'b1;
                    end
                    if (s.phase == PH_DIGIT) begin
                        cand[ncand] = s.held;
                        ncand       = ncand + 1'b1;
                    end
                    s.phase = PH_IDLE;
                    s.held  = '0;
                end
            end
        end

        // capacity check, in order
        for (int k = 0; k < CAND_MAX; k++) begin
            if (k < int'(ncand)) begin
                if (s.written < limit) begin
                    res[cnt[RES_IDX_W-1:0]].data = cand[k];
                    cnt       = cnt + 1'b1;
                    s.written = s.written + 1'b1;
                end else begin
                    s.ovf = 1'b1;
                end
            end
        end

        if (term) begin
            res[cnt[RES_IDX_W-1:0]].term  = 1'b1;
            res[cnt[RES_IDX_W-1:0]].trunc = s.ovf;
            cnt       = cnt + 1'b1;
            s.written = '0;
            s.ovf     = 1'b0;
        end
    end

    assign o_state = s;
    assign o_res   = res;
    assign o_count = cnt;

endmodule

[hw/rtl/url_percent_decode_copy.sv]
// Streaming URL percent decoder with bounded destination.
//
// Input channel i_in carries one raw byte per word plus end_of_string.
// Output channel o_out carries one result per word: a decoded or literal
// byte, or a terminator (is_terminator = 1, out_byte = 0, truncated set if
// any byte of the string was dropped at the capacity limit).
// Config channel i_cfg is always ready: index 0 sets dest_capacity,
// index 1 sets stop_at_zero; other indexes are ignored.
//
// Results of a word appear in the cycle after it is accepted.
// The block takes one input word per cycle while each word causes at most one
// result and the receiver is ready; a word causing more results (up to 4) holds
// the result buffer until all are taken, as the output moves one result per cycle.
// A stalled receiver holds the buffer; input ready drops until the last
// buffered result is taken (it rises in the cycle that result leaves).
// Reset (synchronous, active low) empties the buffer, clears the decode
// state and loads capacity 256 and stop_at_zero 1.
module url_percent_decode_copy import upd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    upd_in_if.sink     i_in,
    upd_out_if.source  o_out,
    upd_cfg_if.sink    i_cfg
);

    // configuration
    logic [CNT_W-1:0] r_cap;
    logic             r_saz;

    // decode state carried between words
    t_state r_state;
    t_state n_state;

    // result buffer: loaded whole on accept, drained one word a cycle while the receiver is ready
    t_res [RES_MAX-1:0]    r_res;
    t_res [RES_MAX-1:0]    n_res;
    logic [RES_CNT_W-1:0]  r_cnt;
    logic [RES_CNT_W-1:0]  n_cnt;
    logic [RES_IDX_W-1:0]  r_rd;

    logic in_take;
    logic out_take;

    assign i_cfg.ready = 1'b1;

    assign out_take   = o_out.valid && o_out.ready;
    // accept when the buffer is empty or its last result leaves now
    assign i_in.ready = (r_cnt == '0)
                     || (r_cnt == RES_CNT_W'(1) && o_out.ready);
    assign in_take    = i_in.valid && i_in.ready;

    upd_step u_step (
        .i_state        (r_state),
        .i_byte         (i_in.in_byte),
        .i_eos          (i_in.end_of_string),
        .i_cap          (r_cap),
        .i_stop_at_zero (r_saz),
        .o_state        (n_state),
        .o_res          (n_res),
        .o_count        (n_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_saz <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEST_CAPACITY: r_cap <= i_cfg.data;
                REG_STOP_AT_ZERO:  r_saz <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
            r_rd    <= '0;
        end else if (in_take) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd    <= '0;
        end else if (out_take) begin
            r_cnt <= r_cnt - 1'b1;
            r_rd  <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = (r_cnt != '0);
    assign o_out.out_byte      = r_res[r_rd].data;
    assign o_out.is_terminator = r_res[r_rd].term;
    assign o_out.truncated     = r_res[r_rd].trunc;

endmodule

[dv/tb_url_percent_decode_copy.sv]
module tb_url_percent_decode_copy;
    import upd_pkg::*;

    // Cycles with no word moving on any channel before the run is abandoned.
    // The slowest legal stretch is a sender gap plus a receiver stall plus the
    // settle wait.
    localparam int IDLE_LIMIT    = 200;
    localparam int GAP_MAX       = 6;
    // Results land in the cycle after their word; a word that leaves nothing
    // behind may still be in flight when the last result arrives.
    localparam int SETTLE_CYCLES = 4;

    // Register indexes the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the decoded stream and holds the results due.
    // ------------------------------------------------------------------
    class pct_decode_scoreboard;
        logic [CNT_W-1:0]  cap;
        logic              stop_zero;
        logic [1:0]        phase;
        logic [BYTE_W-1:0] held;
        logic [CNT_W-1:0]  written;
        logic              ovf;
        logic              skip;
        t_res              due_results[$];
        int                mismatches;

        function new();
            cap        = CAP_RESET;
            stop_zero  = 1'b1;
            phase      = PH_IDLE;
            held       = '0;
            written    = '0;
            ovf        = 1'b0;
            skip       = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            if (idx == REG_DEST_CAPACITY) begin
                cap = val[CNT_W-1:0];
            end else if (idx == REG_STOP_AT_ZERO) begin
                stop_zero = val[0];
            end
        endfunction

        // Digits keep their value in the low nibble; letters fold to lower case.
        function bit hex_nibble(input logic [BYTE_W-1:0] c, output logic [3:0] n);
            logic [BYTE_W-1:0] folded;
            logic [BYTE_W-1:0] t;
            folded = c | 8'h20;
            n = 4'd0;
            if (c >= CHAR_0 && c <= CHAR_9) begin
                n = c[3:0];
                return 1'b1;
            end
            if (folded >= CHAR_LA && folded <= CHAR_LF) begin
                t = folded - CHAR_LA + HEX_ALPHA;
                n = t[3:0];
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void put_data(logic [BYTE_W-1:0] b);
            logic [CNT_W-1:0] room;
            t_res             r;
            room = (cap == '0) ? '0 : cap - 1'b1;
            if (written < room) begin
                r.data  = b;
                r.term  = 1'b0;
                r.trunc = 1'b0;
                due_results.push_back(r);
                written = written + 1'b1;
            end else begin
                ovf = 1'b1;
            end
        endfunction

        function void flush_escape();
            if (phase != PH_IDLE) put_data(CHAR_PCT);
            if (phase == PH_DIGIT) put_data(held);
            phase = PH_IDLE;
            held  = '0;
        endfunction

        function void close_string();
            t_res r;
            flush_escape();
            r.data  = '0;
            r.term  = 1'b1;
            r.trunc = ovf;
            due_results.push_back(r);
            written = '0;
            ovf     = 1'b0;
        endfunction

        // Returns 0 for a word swallowed after a zero-byte stop.
        function bit decode_word(logic [BYTE_W-1:0] b, logic eos);
            logic [3:0] hi;
            logic [3:0] lo;
            logic       fresh;
            if (skip) begin
                if (eos) skip = 1'b0;
                return 1'b0;
            end
            fresh = 1'b1;
            if (phase == PH_PCT) begin
                if (hex_nibble(b, lo)) begin
                    held  = b;
                    phase = PH_DIGIT;
                    fresh = 1'b0;
                end else begin
                    flush_escape();
                end
            end else if (phase == PH_DIGIT) begin
                if (hex_nibble(b, lo)) begin
                    void'(hex_nibble(held, hi));
                    put_data({hi, lo});
                    phase = PH_IDLE;
                    held  = '0;
                    fresh = 1'b0;
                end else begin
                    flush_escape();
                end
            end
            if (fresh) begin
                if (stop_zero && b == CHAR_NUL) begin
                    close_string();
                    skip = !eos;
                    return 1'b1;
                end
                if (b == CHAR_PCT) begin
                    phase = PH_PCT;
                end else begin
                    put_data(b);
                end
            end
            if (eos) close_string();
            return 1'b1;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(t_res got);
            t_res want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result byte %02h term %0b trunc %0b",
                                 got.data, got.term, got.trunc));
                return;
            end
            want = due_results.pop_front();
            if (got.data !== want.data)
                report($sformatf("out_byte %02h, want %02h", got.data, want.data));
            if (got.term !== want.term)
                report($sformatf("is_terminator %0b, want %0b", got.term, want.term));
            if (got.trunc !== want.trunc)
                report($sformatf("truncated %0b, want %0b", got.trunc, want.trunc));
        endtask

        task final_check();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    upd_in_if  in_ch();
    upd_out_if out_ch();
    upd_cfg_if cfg_ch();

    url_percent_decode_copy u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    pct_decode_scoreboard sb = new();

    int                idle_cycles = 0;
    bit                in_calm     = 1'b0; // no sender gaps while set
    bit                out_calm    = 1'b0; // no receiver stalls while set
    logic [BYTE_W-1:0] str_words[$];       // bytes of the string being built

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before any
    // nonblocking update of that edge lands, so ordering within the time
    // step cannot matter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_res got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                void'(sb.decode_word(in_ch.in_byte, in_ch.end_of_string));
            if (out_ch.valid && out_ch.ready) begin
                got.data  = out_ch.out_byte;
                got.term  = out_ch.is_terminator;
                got.trunc = out_ch.truncated;
                sb.check_result(got);
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a fresh random stall, bounded by GAP_MAX, before each result, with
    // stretches of full-rate draining. Stalls also fall while nothing is
    // pending, so they land on every phase of the block's work.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int taken;
        out_ch.ready <= 1'b0;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 8 == 0) out_calm = ($urandom_range(0, 3) == 0);
            stall = out_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. Each is entered just after a rising edge and returns
    // just after the edge that moved its word; valid is left high so that
    // back-to-back words need no second assignment in one step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic eos);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic send_text(input string s, input logic close);
        for (int k = 0; k < s.len(); k++)
            send_word(s[k], close && (k == s.len() - 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // Stop the sender and wait for every result due, then let a word that
    // caused none clear the pipe. The first edge lets the monitor see the
    // word that moved in this very step.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only with the block idle; an open string may span it.
    task automatic set_config(input logic [CNT_W-1:0] cap, input logic stop,
                              input bit spare);
        drain();
        write_reg(REG_DEST_CAPACITY, cap);
        // upper data bits are don't-care for the flag; exercise them anyway
        write_reg(REG_STOP_AT_ZERO,
                  {(CFG_DAT_W-1)'($urandom_range(0, 32767)), stop});
        if (spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CFG_DAT_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random strings: mostly well-formed escapes with random digits and
    // case, mixed with broken escapes, zero bytes and raw noise.
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] rand_hex_char();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom_range(0, 15));
        if (v < HEX_ALPHA) return CHAR_0 + v;
        return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + (v - HEX_ALPHA);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_non_hex();
        logic [BYTE_W-1:0] c;
        logic [3:0]        nib;
        do c = BYTE_W'($urandom_range(0, 255)); while (sb.hex_nibble(c, nib));
        return c;
    endfunction

    function automatic void add_token();
        int                pick;
        logic [BYTE_W-1:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            do c = BYTE_W'($urandom_range(1, 255)); while (c == CHAR_PCT);
            str_words.push_back(c);
        end else if (pick < 68) begin
            str_words.push_back(CHAR_PCT);
            str_words.push_back(rand_hex_char());
            str_words.push_back(rand_hex_char());
        end else if (pick < 76) begin
            str_words.push_back(CHAR_PCT);
            str_words.push_back(rand_non_hex());
        end else if (pick < 83) begin
            str_words.push_back(CHAR_PCT);
            str_words.push_back(rand_hex_char());
            str_words.push_back(rand_non_hex());
        end else if (pick < 88) begin
            str_words.push_back(CHAR_NUL);
        end else if (pick < 93) begin
            str_words.push_back(CHAR_PCT);
        end else begin
            str_words.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endfunction

    // One string in ten is left open so that it runs into the next one.
    // Words past the remaining budget are not sent.
    task automatic send_random_string(input int max_tokens, inout int budget);
        int n_tok;
        bit close;
        str_words.delete();
        n_tok = $urandom_range(1, max_tokens);
        repeat (n_tok) add_token();
        close   = ($urandom_range(0, 9) != 0);
        in_calm = ($urandom_range(0, 3) == 0);
        foreach (str_words[k]) begin
            if (budget > 0) begin
                send_word(str_words[k], close && (k == str_words.size() - 1));
                budget--;
            end
        end
    endtask

    // Sends exactly this many words; the last string may be cut short.
    task automatic run_phase(input int words);
        int budget;
        budget = words;
        while (budget > 0)
            send_random_string(($urandom_range(0, 7) == 0) ? 24 : 8, budget);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= '0;
        in_ch.end_of_string <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: capacity 256, stop at zero on.
        send_text("%00%fF", 1'b1);     // decoded extremes, both digit cases
        send_text("%G%%4", 1'b1);      // bare percent; percent restarts escape; held at end
        send_text("%4z", 1'b1);        // percent, digit, breaker, terminator in one word
        send_word(8'hFF, 1'b0);        // raw top bit set
        send_word(8'h80, 1'b0);
        send_word(CHAR_PCT, 1'b0);
        send_word(CHAR_NUL, 1'b1);     // zero breaks escape and carries the end flag
        send_word("x", 1'b0);
        send_word(CHAR_NUL, 1'b0);     // zero stop mid-string: rest is swallowed
        send_word("y", 1'b0);
        send_word("z", 1'b1);
        send_text("ab%4", 1'b0);       // left open across the next register write

        // Capacity 1: terminators only, every data byte dropped; zero is literal.
        set_config(16'd1, 1'b0, 1'b1);
        run_phase(16);

        // Capacity 0 behaves as 1.
        set_config(16'd0, 1'b1, 1'b0);
        run_phase(10);

        // Short destination: truncation on most strings.
        set_config(16'd4, 1'b1, 1'b1);
        run_phase(22);

        // Largest destination, zero as a plain byte.
        set_config(16'hFFFF, 1'b0, 1'b0);
        run_phase(22);

        repeat (2) begin
            set_config(CNT_W'($urandom_range(2, 12)), 1'($urandom_range(0, 1)), 1'b1);
            run_phase(18);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.final_check();
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
